// ===== sv/cfq_pkg.sv =====
// cfq_pkg: shared types and codes for the circular FIFO queue.
// Used by cfq_cell and circular_fifo_queue; depends on nothing else.
package cfq_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;
  localparam int CNT_W  = 5;
  localparam int ERR_W  = 2;
  localparam int APB_DW = 32;
  localparam int APB_AW = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_DEL = 1'b1;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic [DATA_W-1:0] data_in;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              data_valid;
    logic [CNT_W-1:0]  count;
    logic              is_empty;
    logic              is_full;
    logic [ERR_W-1:0]  error_code;
  } out_word_t;

  // Per-cell control: shift takes the neighbour's word, load takes the new word.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== sv/circular_fifo_queue.sv =====
// circular_fifo_queue: FIFO queue built as a chain of word cells, head in cell 0.
// The result word for an accepted input word is held in the output register from the next cycle on.
// Throughput: one add or delete per cycle, set by the single output register;
// in_stall rises only while a finished result waits under out_stall.
// Reset (rst_n, synchronous, active low): queue empty, capacity 16, no result held.
// Depends on cfq_pkg and cfq_cell.
module circular_fifo_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  cfq_pkg::in_word_t                  in_payload,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output cfq_pkg::out_word_t                 out_payload,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cfq_pkg::APB_AW-1:0]         paddr,
  input  logic [cfq_pkg::APB_DW-1:0]         pwdata,
  output logic [cfq_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);

  // Count width: must hold every value from zero to DEPTH.
  localparam int QCNT_W = $clog2(DEPTH + 1);

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  logic [cfq_pkg::CAP_W-1:0] cap_r, cap_nxt;
  logic [QCNT_W-1:0]         count_r, count_nxt;
  logic                      out_valid_r, out_valid_nxt;
  cfq_pkg::out_word_t        out_r, out_nxt;

  // ---------------------------------------------------------------------------
  // Datapath signals
  // ---------------------------------------------------------------------------
  logic [QCNT_W-1:0]     eff_cap;
  logic                  cfg_wr;
  logic                  accept;
  logic                  is_add;
  logic                  add_ok;
  logic                  del_ok;
  logic [DATA_WIDTH-1:0] word_in;
  logic [DATA_WIDTH-1:0] head_word;

  cfq_pkg::cell_ctrl_t   cell_ctrl [DEPTH];
  logic [DATA_WIDTH-1:0] cell_word [DEPTH];
  logic [DATA_WIDTH-1:0] nbr_word  [DEPTH];

  // ---------------------------------------------------------------------------
  // Configuration port. Only one register, the capacity, at byte offset zero.
  // A write empties the queue; stored words are left but can no longer be read.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = cfq_pkg::APB_DW'(cap_r);

  // Decode the capacity register at offset zero
  logic cfg_addr_hit;
  assign cfg_addr_hit = (paddr == '0);

  always_comb begin
    cap_nxt = cap_r;
    if (cfg_wr && cfg_addr_hit) begin
      cap_nxt = pwdata[cfq_pkg::CAP_W-1:0];
    end
  end

  // Clamp the written capacity into 1..DEPTH: zero acts as one, too large as DEPTH.
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = QCNT_W'(1);
    end else if (32'(cap_r) > 32'(DEPTH)) begin
      eff_cap = QCNT_W'(DEPTH);
    end else begin
      eff_cap = QCNT_W'(cap_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake. The output register parts the two channels: hold the input
  // only while a finished result sits unclaimed.
  // ---------------------------------------------------------------------------
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_add   = (in_payload.cmd == cfq_pkg::CMD_ADD);

  // Refuse an add when full and a delete when empty; neither touches the cells.
  assign add_ok = accept && is_add && (count_r < eff_cap);
  assign del_ok = accept && !is_add && (count_r != '0);

  assign word_in   = DATA_WIDTH'(in_payload.data_in);
  assign head_word = cell_word[0];

  // ---------------------------------------------------------------------------
  // Cell chain. Cell 0 holds the head; cell count_r is the next free slot.
  // A delete moves every word one cell toward the head.
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == DEPTH - 1) begin : g_last
      assign nbr_word[g] = '0;
    end else begin : g_mid
      assign nbr_word[g] = cell_word[g + 1];
    end

    assign cell_ctrl[g].shift = del_ok;
    assign cell_ctrl[g].load  = add_ok && (count_r == QCNT_W'(g));

    cfq_cell #(
      .DW (DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[g]),
      .load_word (word_in),
      .nbr_word  (nbr_word[g]),
      .word      (cell_word[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Element count: drop to zero on a capacity write, else track adds and deletes.
  // ---------------------------------------------------------------------------
  always_comb begin
    count_nxt = count_r;
    if (cfg_wr && cfg_addr_hit) begin
      count_nxt = '0;
    end else if (add_ok) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (del_ok) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Result word, built from the state after this item's operation.
  // ---------------------------------------------------------------------------
  logic [QCNT_W-1:0] res_count;

  always_comb begin
    if (add_ok) begin
      res_count = count_r + QCNT_W'(1);
    end else if (del_ok) begin
      res_count = count_r - QCNT_W'(1);
    end else begin
      res_count = count_r;
    end
  end

  always_comb begin
    out_nxt            = out_r;
    out_nxt.data_out   = del_ok ? cfq_pkg::DATA_W'(head_word) : '0;
    out_nxt.data_valid = del_ok;
    out_nxt.count      = cfq_pkg::CNT_W'(res_count);
    out_nxt.is_empty   = (res_count == '0);
    out_nxt.is_full    = (res_count == eff_cap);
    if (accept && is_add && !add_ok) begin
      out_nxt.error_code = cfq_pkg::ERR_FULL;
    end else if (accept && !is_add && !del_ok) begin
      out_nxt.error_code = cfq_pkg::ERR_EMPTY;
    end else begin
      out_nxt.error_code = cfq_pkg::ERR_OK;
    end
  end

  // Load on accept; otherwise hold while stalled and drop once taken.
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= cfq_pkg::CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload register: no reset needed, qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef SYNTH
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= eff_cap)
    else $error("element count beyond capacity");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_add && count_r == eff_cap && !cfg_wr) |=>
      (out_payload.error_code == cfq_pkg::ERR_FULL && $stable(count_r)))
    else $error("add on a full queue not refused");

  a_empty_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_add && count_r == '0 && !cfg_wr) |=>
      (out_payload.error_code == cfq_pkg::ERR_EMPTY && !out_payload.data_valid))
    else $error("delete on an empty queue not refused");

  a_cfg_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && cfg_addr_hit) |=> (count_r == '0))
    else $error("capacity write did not empty the queue");
`endif

endmodule

// ===== sv/cfq_cell.sv =====
// cfq_cell: one storage cell of the queue chain.
// Depends on cfq_pkg for the cell control struct.
module cfq_cell #(
  parameter int DW = 32
) (
  input  logic                clk,
  input  cfq_pkg::cell_ctrl_t ctrl,
  input  logic [DW-1:0]       load_word,
  input  logic [DW-1:0]       nbr_word,
  output logic [DW-1:0]       word
);

  logic [DW-1:0] word_r;

  // Shift toward the head on a delete; take the new word when this is the tail slot.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      word_r <= nbr_word;
    end else if (ctrl.load) begin
      word_r <= load_word;
    end
  end

  assign word = word_r;

endmodule

// ===== tb/sv/circular_fifo_queue_tb.sv =====
// circular_fifo_queue_tb: self-checking bench for the circular FIFO queue.
// Holds a queue model in a small scoreboard class and drives the block through
// plain tasks; depends on cfq_pkg and the circular_fifo_queue RTL.
`timescale 1ns / 100ps

module circular_fifo_queue_tb;

  localparam int RING_DEPTH     = 16;
  localparam int SEGMENTS       = 15;
  localparam int SEG_WORDS      = 60;
  localparam int DRAIN_CYCLES   = 3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [cfq_pkg::APB_AW-1:0] CAP_ADDR = '0;  // capacity register, index 0

  // Queue model: positions run 1..ring size, 0 in both marks the empty queue.
  class fifo_scoreboard;
    logic [cfq_pkg::DATA_W-1:0] slots [RING_DEPTH];
    int unsigned                head_pos;
    int unsigned                tail_pos;
    logic [cfq_pkg::CAP_W-1:0]  cap_reg;
    cfq_pkg::out_word_t         pending_status [$];
    int unsigned                mismatches;

    function new();
      head_pos   = 0;
      tail_pos   = 0;
      cap_reg    = cfq_pkg::CAP_RESET;
      mismatches = 0;
    endfunction

    // Clamp the written capacity to 1..depth.
    function int unsigned ring();
      if (cap_reg < 1) return 1;
      if (cap_reg > RING_DEPTH) return RING_DEPTH;
      return 32'(cap_reg);
    endfunction

    function int unsigned held();
      if (head_pos == 0 && tail_pos == 0) return 0;
      if (tail_pos >= head_pos) return tail_pos - head_pos + 1;
      return ring() - head_pos + 1 + tail_pos;
    endfunction

    function int unsigned step_pos(int unsigned p);
      return (p >= ring()) ? 1 : p + 1;
    endfunction

    // A capacity write empties the queue; stored words are kept but unreachable.
    function void set_capacity(logic [cfq_pkg::CAP_W-1:0] val);
      cap_reg  = val;
      head_pos = 0;
      tail_pos = 0;
    endfunction

    function void note_input(cfq_pkg::in_word_t w);
      cfq_pkg::out_word_t res;
      int unsigned        n;
      res = '0;
      n   = held();
      if (w.cmd == cfq_pkg::CMD_ADD) begin
        if (n >= ring()) begin
          res.error_code = cfq_pkg::ERR_FULL;
        end else begin
          if (n == 0) begin
            head_pos = 1;
            tail_pos = 1;
          end else begin
            tail_pos = step_pos(tail_pos);
          end
          slots[tail_pos - 1] = w.data_in;
        end
      end else begin
        if (n == 0) begin
          res.error_code = cfq_pkg::ERR_EMPTY;
        end else begin
          res.data_out   = slots[head_pos - 1];
          res.data_valid = 1'b1;
          if (head_pos == tail_pos) begin
            head_pos = 0;
            tail_pos = 0;
          end else begin
            head_pos = step_pos(head_pos);
          end
        end
      end
      n            = held();
      res.count    = cfq_pkg::CNT_W'(n);
      res.is_empty = (n == 0);
      res.is_full  = (n == ring());
      pending_status.push_back(res);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(cfq_pkg::out_word_t got);
      cfq_pkg::out_word_t want;
      if (pending_status.size() == 0) begin
        report("unexpected result word", 64'(got.data_out), 64'd0);
        return;
      end
      want = pending_status.pop_front();
      if (got.data_out !== want.data_out)
        report("data_out", 64'(got.data_out), 64'(want.data_out));
      if (got.data_valid !== want.data_valid)
        report("data_valid", 64'(got.data_valid), 64'(want.data_valid));
      if (got.count !== want.count)
        report("count", 64'(got.count), 64'(want.count));
      if (got.is_empty !== want.is_empty)
        report("is_empty", 64'(got.is_empty), 64'(want.is_empty));
      if (got.is_full !== want.is_full)
        report("is_full", 64'(got.is_full), 64'(want.is_full));
      if (got.error_code !== want.error_code)
        report("error_code", 64'(got.error_code), 64'(want.error_code));
    endtask
  endclass

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_valid   = 1'b0;
  logic                       in_stall;
  cfq_pkg::in_word_t          in_payload = '0;
  logic                       out_valid;
  logic                       out_stall  = 1'b0;
  cfq_pkg::out_word_t         out_payload;
  logic                       psel       = 1'b0;
  logic                       penable    = 1'b0;
  logic                       pwrite     = 1'b0;
  logic [cfq_pkg::APB_AW-1:0] paddr      = '0;
  logic [cfq_pkg::APB_DW-1:0] pwdata     = '0;
  logic [cfq_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  fifo_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles  = 0;

  // Capacities visited by the random segments: both clamp ends and the limits.
  logic [cfq_pkg::CAP_W-1:0] cap_plan [SEGMENTS] =
    '{5'd16, 5'd1, 5'd0, 5'd2, 5'd31, 5'd17, 5'd5, 5'd16,
      5'd3, 5'd9, 5'd1, 5'd16, 5'd12, 5'd0, 5'd7};

  circular_fifo_queue u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #6 clk = ~clk;

  // Receiver back-pressure: redraw the stall every cycle at the current rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Sample both channels mid-cycle: inputs only move at the rising edge, so
  // what is seen here is exactly what the next edge will accept. Results are
  // checked before the new input is noted; either order holds, as a result
  // always belongs to an earlier word.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_payload);
      if (in_valid && !in_stall) sb.note_input(in_payload);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  function automatic logic [cfq_pkg::DATA_W-1:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Offer one word, idling first at the sender's rate; return on the
  // accepting edge with valid still high, so the next word follows at once.
  task automatic send_word(input logic op, input logic [cfq_pkg::DATA_W-1:0] word_val);
    bit fire;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_payload.cmd     <= op;
    in_payload.data_in <= word_val;
    fire = 1'b0;
    while (!fire) begin
      @(negedge clk);
      fire = !in_stall;
      @(posedge clk);
    end
  endtask

  // Drop valid, wait for every expected result, then let the pipe settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup then access phase; the write lands on the edge with pready high.
  task automatic write_capacity(input logic [cfq_pkg::CAP_W-1:0] val);
    bit done;
    wait_idle();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CAP_ADDR;
    pwdata  <= cfq_pkg::APB_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    done = 1'b0;
    while (!done) begin
      @(negedge clk);
      done = pready;
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_capacity(val);
  endtask

  initial begin
    int unsigned run_left;
    int unsigned add_pct;
    run_left = 0;
    add_pct  = 50;

    // Hold reset, once only.
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 18;
    recv_idle_pct = 74;

    // Reset capacity: delete when empty, data extremes, drain past empty.
    send_word(cfq_pkg::CMD_DEL, 32'h1234_5678);
    send_word(cfq_pkg::CMD_ADD, 32'h0000_0000);
    send_word(cfq_pkg::CMD_ADD, 32'hFFFF_FFFF);
    send_word(cfq_pkg::CMD_ADD, 32'hA5A5_A5A5);
    send_word(cfq_pkg::CMD_DEL, 32'hFFFF_FFFF);
    send_word(cfq_pkg::CMD_DEL, 32'h0);
    send_word(cfq_pkg::CMD_DEL, 32'h0);
    send_word(cfq_pkg::CMD_DEL, 32'h0);

    // Single slot: a second add is refused as full.
    write_capacity(5'd1);
    send_word(cfq_pkg::CMD_ADD, 32'h0000_0001);
    send_word(cfq_pkg::CMD_ADD, 32'h0000_0002);
    send_word(cfq_pkg::CMD_DEL, 32'h0);
    send_word(cfq_pkg::CMD_DEL, 32'h0);

    // Two slots: leave a lone element away from slot 1, then wrap the tail.
    write_capacity(5'd2);
    send_word(cfq_pkg::CMD_ADD, 32'hCAFE_0001);
    send_word(cfq_pkg::CMD_ADD, 32'hCAFE_0002);
    send_word(cfq_pkg::CMD_ADD, 32'hCAFE_0003);
    send_word(cfq_pkg::CMD_DEL, 32'h0);
    send_word(cfq_pkg::CMD_ADD, 32'hCAFE_0004);
    send_word(cfq_pkg::CMD_DEL, 32'h0);
    send_word(cfq_pkg::CMD_DEL, 32'h0);
    send_word(cfq_pkg::CMD_DEL, 32'h0);

    // Rewrite capacity with words held: the queue must come back empty, and
    // a written zero must act as a single slot.
    write_capacity(5'd3);
    send_word(cfq_pkg::CMD_ADD, 32'h5555_5555);
    send_word(cfq_pkg::CMD_ADD, 32'hAAAA_AAAA);
    write_capacity(5'd0);
    send_word(cfq_pkg::CMD_DEL, 32'h0);
    send_word(cfq_pkg::CMD_ADD, 32'h7FFF_FFFF);
    send_word(cfq_pkg::CMD_ADD, 32'h8000_0000);

    // Random segments: bursts biased towards filling or draining so the
    // queue swings between empty and full at each capacity.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 5) begin
        send_idle_pct = 74;
        recv_idle_pct = 18;
      end else if (seg == 10) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_capacity(cap_plan[seg]);
      for (int n = 0; n < SEG_WORDS; n++) begin
        if (run_left == 0) begin
          case ($urandom_range(0, 2))
            0:       add_pct = 80;
            1:       add_pct = 20;
            default: add_pct = 50;
          endcase
          run_left = $urandom_range(4, 40);
        end
        run_left--;
        send_word(($urandom_range(0, 99) < add_pct) ? cfq_pkg::CMD_ADD : cfq_pkg::CMD_DEL,
                  rand_word());
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_status.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/cfq_pkg.sv
sv/cfq_cell.sv
sv/circular_fifo_queue.sv
tb/sv/circular_fifo_queue_tb.sv
